// ----- rtl/pair_sum_index_search_macros.svh -----
// Assertion macros for the pair sum index search block.
// Used by files that assert; expects signals clk and rst_n in scope.
`ifndef PAIR_SUM_INDEX_SEARCH_MACROS_SVH
`define PAIR_SUM_INDEX_SEARCH_MACROS_SVH

// same-cycle implication
`define PSIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psis_pkg.sv -----
// Package for the pair sum index search block: request and result types,
// status codes and default sizes. No dependencies.
package psis_pkg;

  localparam int PSIS_ENTRIES = 256;
  localparam int VALUE_W      = 32;
  localparam int INDEX_W      = 8;

  typedef enum logic [1:0] {
    STATUS_STORED  = 2'd0,
    STATUS_PAIR    = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_IGNORED = 2'd3
  } psis_status_t;

  typedef struct packed {
    logic                      start_of_list;
    logic signed [VALUE_W-1:0] value;
  } psis_in_t;

  typedef struct packed {
    psis_status_t       status;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
  } psis_out_t;

endpackage

// ----- rtl/pair_sum_index_search.sv -----
// Top level of the pair sum index search block: sequencer, compare unit.
// Depends on psis_pkg, psis_ram and pair_sum_index_search_macros.svh.
//
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | psis_in_t (start_of_list, value)
//  out_    | out       | out_valid/out_stall| psis_out_t (status, indices)
//  cfg_    | in        | cfg_valid/cfg_ready| target_sum, 32 bits signed
//
// A searched request scans the store one slot per cycle through the single read
// port of the value RAM, up to the first hit or to the end of the stored items.
// Requests ignored after an answer or dropped on a full store skip the scan and
// go straight to the emit step.
// A stalled result holds the sequencer in its emit step; one request at a time.
// Reset clears the count, the answer flag, the target and the result valid;
// the RAM needs no clearing since only slots below the count are read.
`include "pair_sum_index_search_macros.svh"

module pair_sum_index_search import psis_pkg::*; #(
  parameter int ENTRIES = PSIS_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  psis_in_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output psis_out_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic signed [VALUE_W-1:0] cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int DW = VALUE_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [VALUE_W-1:0] target_r, target_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic signed [VALUE_W:0]   comp_r, comp_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      found_r, found_nxt;
  logic [CW-1:0]             scan_addr_r, scan_addr_nxt;
  logic [CW-1:0]             cmp_slot_r, cmp_slot_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic                      dup_r, dup_nxt;
  psis_out_t                 res_r, res_nxt;
  psis_out_t                 out_data_r, out_data_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic                      mem_we;
  logic [DW-1:0]             mem_rdata;
  logic                      slot_stored;
  logic                      comp_hit;
  logic                      val_hit;
  logic [CW-1:0]             cnt_eff;
  logic                      fnd_eff;

  psis_ram #(
    .DEPTH (ENTRIES),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({~dup_r, val_r}),
    .raddr (scan_addr_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  // top bit of a RAM word marks a slot that holds a first occurrence
  assign slot_stored = mem_rdata[DW-1];
  assign comp_hit    = slot_stored &&
                       ($signed({mem_rdata[VALUE_W-1], mem_rdata[VALUE_W-1:0]}) == comp_r);
  assign val_hit     = slot_stored && (mem_rdata[VALUE_W-1:0] == val_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    val_nxt       = val_r;
    comp_nxt      = comp_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    scan_addr_nxt = scan_addr_r;
    cmp_slot_nxt  = cmp_slot_r;
    cmp_vld_nxt   = cmp_vld_r;
    dup_nxt       = dup_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    cnt_eff       = in_data.start_of_list ? '0 : count_r;
    fnd_eff       = in_data.start_of_list ? 1'b0 : found_r;

    if (cfg_valid) begin
      target_nxt = cfg_data;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt       = in_data.value;
          comp_nxt      = $signed({target_r[VALUE_W-1], target_r}) -
                          $signed({in_data.value[VALUE_W-1], in_data.value});
          count_nxt     = cnt_eff;
          found_nxt     = fnd_eff;
          scan_addr_nxt = '0;
          cmp_vld_nxt   = 1'b0;
          dup_nxt       = 1'b0;
          res_nxt       = '{status: STATUS_STORED, first_index: '0, second_index: '0};
          if (fnd_eff) begin
            res_nxt.status = STATUS_IGNORED;
            state_nxt      = ST_EMIT;
          end else if (cnt_eff == CW'(ENTRIES)) begin
            res_nxt.status = STATUS_FULL;
            state_nxt      = ST_EMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_addr_r < count_r) begin
          cmp_vld_nxt   = 1'b1;
          cmp_slot_nxt  = scan_addr_r;
          scan_addr_nxt = scan_addr_r + CW'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (cmp_vld_r && comp_hit) begin
          res_nxt.status       = STATUS_PAIR;
          res_nxt.first_index  = INDEX_W'(cmp_slot_r);
          res_nxt.second_index = INDEX_W'(count_r);
          found_nxt            = 1'b1;
          count_nxt            = count_r + CW'(1);
          state_nxt            = ST_EMIT;
        end else if (cmp_vld_r) begin
          if (val_hit) begin
            dup_nxt = 1'b1;
          end
        end else if (scan_addr_r == count_r) begin
          // miss: the slot is written even for a repeat, with its flag clear
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= '0;
      count_r     <= '0;
      found_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r       <= val_nxt;
    comp_r      <= comp_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    dup_r       <= dup_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  `PSIS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(ENTRIES), "item count beyond store depth")
  `PSIS_ASSERT_NOW(a_scan_bound, state_r == ST_SCAN, scan_addr_r <= count_r, "scan beyond count")
  `PSIS_ASSERT_NEXT(a_write_counts, mem_we, count_r == $past(count_r) + CW'(1), "write w/o count step")
  `PSIS_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != ST_IDLE, "request not taken up")
  `PSIS_ASSERT_NOW(a_cmp_in_range, state_r == ST_SCAN && cmp_vld_r, cmp_slot_r < count_r, "compare slot out of range")

endmodule

// ----- rtl/psis_ram.sv -----
// Value store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module psis_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 33
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
